// ===== sv/rfpdc_pkg.sv =====
// types and constants shared by the rf packet deframer and checker
package rfpdc_pkg;

	typedef enum logic [1:0] {
		PH_HUNT = 2'd0,
		PH_LEN  = 2'd1,
		PH_DATA = 2'd2
	} phase_t;

	typedef enum logic [2:0] {
		ST_OK       = 3'd0,
		ST_RESERVED = 3'd1,
		ST_ADDRESS  = 3'd2,
		ST_CHECKSUM = 3'd3,
		ST_SUBTYPE  = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		RP_NONE     = 2'd0,
		RP_CAR_ACK  = 2'd1,
		RP_TIME_SYNC = 2'd2
	} reply_t;

	localparam logic [7:0]  START_DETECTOR = 8'h55;
	localparam logic [7:0]  START_TOOL     = 8'h66;
	localparam logic [7:0]  RESERVED_HI    = 8'h52; // 'R'
	localparam logic [7:0]  RESERVED_LO    = 8'h46; // 'F'
	localparam logic [15:0] BROADCAST_ADDR = 16'd1999;
	localparam logic [15:0] OWN_ADDR_RESET = 16'd1001;
	localparam logic [7:0]  MIN_PACKET_BYTES = 8'd12;

	localparam logic [7:0]  SUB_FORWARD    = 8'd21;
	localparam logic [7:0]  SUB_CAR_INFO   = 8'd22;
	localparam logic [7:0]  SUB_TIME_SYNC  = 8'd23;
	localparam logic [7:0]  SUB_QUIET      = 8'd24;

	// byte positions inside a packet
	localparam int unsigned POS_SUBTYPE  = 2;
	localparam int unsigned POS_RSV_HI   = 3;
	localparam int unsigned POS_RSV_LO   = 4;
	localparam int unsigned POS_CHECK    = 5;
	localparam int unsigned POS_SRC_HI   = 6;
	localparam int unsigned POS_SRC_LO   = 7;
	localparam int unsigned POS_DST_HI   = 8;
	localparam int unsigned POS_DST_LO   = 9;

endpackage

// ===== sv/rf_packet_deframer_checker.sv =====
// Byte-serial RF packet deframer and checker. One received byte is taken per
// word on the input channel, and the block accepts a word in every cycle while
// the result side keeps up. An accepted byte is held in the input register,
// where the framing state is updated by compare and XOR logic, and the result
// of a packet's last byte is registered in the result register. The result
// register parts the two sides, so a new byte is taken while a finished result
// waits. A packet gives exactly one result word; bytes outside a frame and
// frames with a length below 12 or of MAX_PACKET_BYTES or more give none. The
// user must write own_address through the configuration channel only while the
// block is idle; the block itself does not enforce this.
module rf_packet_deframer_checker
	import rfpdc_pkg::*;
#(
	parameter int unsigned MAX_PACKET_BYTES = 128
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [15:0] cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  rx_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  status,
	output logic        from_tool,
	output logic [7:0]  sub_type,
	output logic [15:0] source_address,
	output logic [6:0]  packet_length,
	output logic        forward_to_host,
	output logic [1:0]  reply_kind
);

	localparam int unsigned CW = $clog2(MAX_PACKET_BYTES);

	// configuration
	logic [15:0] own_address_q;

	// input register
	logic        valid_s1;
	logic [7:0]  byte_s1;

	// framing state
	phase_t      phase_q, phase_d;
	logic [CW-1:0] count_q, count_d;
	logic [CW-1:0] exp_len_q, exp_len_d;
	logic [7:0]  xor_q, xor_d;
	logic [7:0]  chk_q, chk_d;
	logic [7:0]  sub_q, sub_d;
	logic        tool_q, tool_d;
	logic        rsv_ok_q, rsv_ok_d;
	logic [15:0] src_q, src_d;
	logic [15:0] dst_q, dst_d;

	// values after taking the current byte as data
	logic [7:0]  xor_t, chk_t, sub_t;
	logic        rsv_ok_t;
	logic [15:0] src_t, dst_t;
	logic [CW:0] count_inc;
	logic        last_byte, bad_len, is_start;

	// result
	status_t     res_status;
	logic        res_fwd;
	reply_t      res_reply;
	logic        advance, step, emit, closing;

	logic        out_valid_q;
	logic [2:0]  status_q;
	logic        from_tool_q;
	logic [7:0]  sub_type_q;
	logic [15:0] source_q;
	logic [6:0]  length_q;
	logic        fwd_q;
	logic [1:0]  reply_q;

	assign cfg_ready = 1'b1;
	assign advance   = !out_valid_q || out_ready;
	// only a packet's last byte has to wait for a free result register
	assign closing   = (phase_q == PH_DATA) && last_byte;
	assign step      = valid_s1 && (advance || !closing);
	assign in_ready  = !valid_s1 || step;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_address_q <= OWN_ADDR_RESET;
		end else if (cfg_valid) begin
			own_address_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1 <= rx_byte;
		end
	end

	// data byte update
	always_comb begin
		xor_t    = xor_q;
		chk_t    = chk_q;
		sub_t    = sub_q;
		rsv_ok_t = rsv_ok_q;
		src_t    = src_q;
		dst_t    = dst_q;
		if (count_q == CW'(POS_CHECK)) begin
			chk_t = byte_s1;
		end else begin
			xor_t = xor_q ^ byte_s1;
		end
		if (count_q == CW'(POS_SUBTYPE)) begin
			sub_t = byte_s1;
		end else if (count_q == CW'(POS_RSV_HI) && byte_s1 != RESERVED_HI) begin
			rsv_ok_t = 1'b0;
		end else if (count_q == CW'(POS_RSV_LO) && byte_s1 != RESERVED_LO) begin
			rsv_ok_t = 1'b0;
		end else if (count_q == CW'(POS_SRC_HI)) begin
			src_t = {byte_s1, src_q[7:0]};
		end else if (count_q == CW'(POS_SRC_LO)) begin
			src_t = {src_q[15:8], byte_s1};
		end else if (count_q == CW'(POS_DST_HI)) begin
			dst_t = {byte_s1, dst_q[7:0]};
		end else if (count_q == CW'(POS_DST_LO)) begin
			dst_t = {dst_q[15:8], byte_s1};
		end
	end

	assign count_inc = {1'b0, count_q} + (CW+1)'(1);
	assign last_byte = count_inc >= {1'b0, exp_len_q};
	assign bad_len   = (byte_s1 < MIN_PACKET_BYTES)
		|| ({1'b0, byte_s1} >= 9'(MAX_PACKET_BYTES));
	assign is_start  = (byte_s1 == START_DETECTOR) || (byte_s1 == START_TOOL);

	// checks, first failing one wins
	always_comb begin
		res_status = ST_OK;
		res_fwd    = 1'b0;
		res_reply  = RP_NONE;
		if (!rsv_ok_t) begin
			res_status = ST_RESERVED;
		end else if (dst_t != own_address_q && dst_t != BROADCAST_ADDR) begin
			res_status = ST_ADDRESS;
		end else if (xor_t != chk_t) begin
			res_status = ST_CHECKSUM;
		end else if (!tool_q) begin
			case (sub_t)
				SUB_FORWARD: begin
					res_fwd = 1'b1;
				end
				SUB_CAR_INFO: begin
					res_fwd   = 1'b1;
					res_reply = RP_CAR_ACK;
				end
				SUB_TIME_SYNC: begin
					res_reply = RP_TIME_SYNC;
				end
				SUB_QUIET: begin
					res_status = ST_OK;
				end
				default: begin
					res_status = ST_SUBTYPE;
				end
			endcase
		end
	end

	assign emit = step && closing;

	// next framing state
	always_comb begin
		phase_d   = phase_q;
		count_d   = count_q;
		exp_len_d = exp_len_q;
		xor_d     = xor_q;
		chk_d     = chk_q;
		sub_d     = sub_q;
		tool_d    = tool_q;
		rsv_ok_d  = rsv_ok_q;
		src_d     = src_q;
		dst_d     = dst_q;
		if (step) begin
			case (phase_q)
				PH_LEN: begin
					if (bad_len) begin
						phase_d   = PH_HUNT;
						count_d   = '0;
						exp_len_d = '0;
						xor_d     = '0;
						chk_d     = '0;
						rsv_ok_d  = 1'b1;
					end else begin
						phase_d   = PH_DATA;
						count_d   = CW'(2);
						exp_len_d = byte_s1[CW-1:0];
						xor_d     = xor_q ^ byte_s1;
					end
				end
				PH_DATA: begin
					sub_d = sub_t;
					src_d = src_t;
					dst_d = dst_t;
					if (last_byte) begin
						phase_d   = PH_HUNT;
						count_d   = '0;
						exp_len_d = '0;
						xor_d     = '0;
						chk_d     = '0;
						rsv_ok_d  = 1'b1;
					end else begin
						count_d  = count_inc[CW-1:0];
						xor_d    = xor_t;
						chk_d    = chk_t;
						rsv_ok_d = rsv_ok_t;
					end
				end
				default: begin
					// hunt, also the unused phase code
					if (is_start) begin
						phase_d   = PH_LEN;
						count_d   = CW'(1);
						exp_len_d = '0;
						xor_d     = byte_s1;
						chk_d     = '0;
						rsv_ok_d  = 1'b1;
						tool_d    = (byte_s1 == START_TOOL);
					end else begin
						phase_d = PH_HUNT;
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_HUNT;
			count_q   <= '0;
			exp_len_q <= '0;
			xor_q     <= '0;
			chk_q     <= '0;
			sub_q     <= '0;
			tool_q    <= 1'b0;
			rsv_ok_q  <= 1'b1;
			src_q     <= '0;
			dst_q     <= '0;
		end else begin
			phase_q   <= phase_d;
			count_q   <= count_d;
			exp_len_q <= exp_len_d;
			xor_q     <= xor_d;
			chk_q     <= chk_d;
			sub_q     <= sub_d;
			tool_q    <= tool_d;
			rsv_ok_q  <= rsv_ok_d;
			src_q     <= src_d;
			dst_q     <= dst_d;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= emit;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			status_q    <= res_status;
			from_tool_q <= tool_q;
			sub_type_q  <= sub_t;
			source_q    <= src_t;
			length_q    <= 7'(exp_len_q);
			fwd_q       <= res_fwd;
			reply_q     <= res_reply;
		end
	end

	assign out_valid       = out_valid_q;
	assign status          = status_q;
	assign from_tool       = from_tool_q;
	assign sub_type        = sub_type_q;
	assign source_address  = source_q;
	assign packet_length   = length_q;
	assign forward_to_host = fwd_q;
	assign reply_kind      = reply_q;

endmodule
